@@ rtl/core/pcab_pkg.sv @@
// Package for the polygon convexity, area and bounds block.
// Holds the coordinate, count and area widths and the payload and stage structs.
// No dependencies.
package pcab_pkg;

	localparam int COORD_W      = 16;
	localparam int MAX_VERTICES = 1024;
	localparam int COUNT_W      = $clog2(MAX_VERTICES + 1);
	localparam int AREA_W       = 44;
	localparam int DIFF_W       = COORD_W + 1;
	localparam int PROD_W       = 2 * DIFF_W;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [DIFF_W-1:0]  diff_t;
	typedef logic signed [PROD_W-1:0]  prod_t;
	typedef logic signed [AREA_W-1:0]  area_t;
	typedef logic        [COUNT_W-1:0] count_t;

	localparam count_t MAX_COUNT = count_t'(MAX_VERTICES);
	localparam count_t MIN_TURNS = count_t'(3);

	typedef struct packed {
		coord_t x;
		coord_t y;
	} pt_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		logic   last;
	} vertex_t;

	typedef struct packed {
		logic   convex;
		area_t  double_area;
		coord_t min_x;
		coord_t min_y;
		coord_t max_x;
		coord_t max_y;
		count_t vertex_count;
	} result_t;

	typedef struct packed {
		coord_t min_x;
		coord_t min_y;
		coord_t max_x;
		coord_t max_y;
	} bbox_t;

	// Points for every turn and edge that one vertex closes.
	typedef struct packed {
		logic   last;
		logic   ta_en;
		logic   ea_en;
		logic   close_en;
		pt_t    v;
		pt_t    p;
		pt_t    o;
		pt_t    f;
		pt_t    s;
		bbox_t  box;
		count_t cnt;
	} s1_t;

	typedef struct packed {
		logic   last;
		logic   ta_en;
		logic   ea_en;
		logic   close_en;
		prod_t  ta_m1;
		prod_t  ta_m2;
		prod_t  tb_m1;
		prod_t  tb_m2;
		prod_t  tc_m1;
		prod_t  tc_m2;
		prod_t  ea;
		prod_t  eb;
		bbox_t  box;
		count_t cnt;
	} s2_t;

endpackage

@@ rtl/core/polygon_convexity_area_bounds.sv @@
// Streaming polygon convexity test, doubled shoelace area and bounding box.
// Throughput: one vertex per cycle unless stalled, set by the single area and sign-flag
// update per cycle. A last vertex passes the first-stage, product and result registers.
// A waiting result stalls only a last vertex at the accumulator; vertices behind it wait.
// Reset (arst_n low, asynchronous) clears all vertex state, accumulators and valid flags.
// Depends on pcab_pkg, pcab_front, pcab_prod and pcab_acc.
module polygon_convexity_area_bounds import pcab_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    vertex_valid,
	output logic    vertex_ready,
	input  vertex_t vertex,
	output logic    result_valid,
	input  logic    result_ready,
	output result_t result
);

	logic s1_valid, s1_ready;
	s1_t  s1;
	logic s2_valid, s2_ready;
	s2_t  s2;

	pcab_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.vertex_valid (vertex_valid),
		.vertex_ready (vertex_ready),
		.vertex       (vertex),
		.s1_valid     (s1_valid),
		.s1_ready     (s1_ready),
		.s1           (s1)
	);

	pcab_prod u_prod (
		.clk      (clk),
		.arst_n   (arst_n),
		.s1_valid (s1_valid),
		.s1_ready (s1_ready),
		.s1       (s1),
		.s2_valid (s2_valid),
		.s2_ready (s2_ready),
		.s2       (s2)
	);

	pcab_acc u_acc (
		.clk          (clk),
		.arst_n       (arst_n),
		.s2_valid     (s2_valid),
		.s2_ready     (s2_ready),
		.s2           (s2),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	// A reported count is never zero and never beyond the saturation limit.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.vertex_count != '0) && (result.vertex_count <= MAX_COUNT))
		else $error("vertex count out of range");

	// The bounding box is never inverted.
	a_box_order: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> ($signed(result.min_x) <= $signed(result.max_x)) &&
		                 ($signed(result.min_y) <= $signed(result.max_y)))
		else $error("bounding box inverted");

	// Fewer than three vertices always report a convex shape.
	a_small_convex: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && (result.vertex_count < MIN_TURNS)) |-> result.convex)
		else $error("small polygon reported non-convex");

	// An empty first stage never holds off the input.
	a_front_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!s1_valid |-> vertex_ready)
		else $error("input stalled with empty first stage");

endmodule

@@ rtl/core/pcab_front.sv @@
// Vertex tracker: first, second, older and prior vertices, count and bounds.
// Forms the operand points for the multiply stage. Depends on pcab_pkg.
module pcab_front import pcab_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    vertex_valid,
	output logic    vertex_ready,
	input  vertex_t vertex,
	output logic    s1_valid,
	input  logic    s1_ready,
	output s1_t     s1
);

	pt_t    first_q, second_q, older_q, prior_q;
	count_t count_q;
	bbox_t  box_q;
	logic   s1_valid_q;
	s1_t    s1_q;

	pt_t    v;
	logic   cnt0, cnt1;
	count_t cnt_new;
	bbox_t  box_new;
	s1_t    s1_d;
	logic   take;

	assign vertex_ready = !s1_valid_q || s1_ready;
	assign take         = vertex_valid && vertex_ready;
	assign s1_valid     = s1_valid_q;
	assign s1           = s1_q;

	always_comb begin
		v.x     = vertex.x;
		v.y     = vertex.y;
		cnt0    = (count_q == '0);
		cnt1    = (count_q == count_t'(1));
		cnt_new = (count_q < MAX_COUNT) ? count_q + count_t'(1) : count_q;
		if (cnt0) begin
			box_new = '{min_x: v.x, min_y: v.y, max_x: v.x, max_y: v.y};
		end else begin
			box_new.min_x = ($signed(v.x) < $signed(box_q.min_x)) ? v.x : box_q.min_x;
			box_new.min_y = ($signed(v.y) < $signed(box_q.min_y)) ? v.y : box_q.min_y;
			box_new.max_x = ($signed(v.x) > $signed(box_q.max_x)) ? v.x : box_q.max_x;
			box_new.max_y = ($signed(v.y) > $signed(box_q.max_y)) ? v.y : box_q.max_y;
		end
		s1_d.last     = vertex.last;
		s1_d.ta_en    = !cnt0 && !cnt1;
		s1_d.ea_en    = !cnt0;
		s1_d.close_en = vertex.last && (cnt_new >= MIN_TURNS);
		s1_d.v        = v;
		s1_d.p        = prior_q;
		s1_d.o        = older_q;
		s1_d.f        = cnt0 ? v : first_q;
		s1_d.s        = second_q;
		s1_d.box      = box_new;
		s1_d.cnt      = cnt_new;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q    <= '0;
			second_q   <= '0;
			older_q    <= '0;
			prior_q    <= '0;
			count_q    <= '0;
			box_q      <= '0;
			s1_valid_q <= 1'b0;
		end else begin
			if (take) begin
				s1_valid_q <= 1'b1;
				if (vertex.last) begin
					first_q  <= '0;
					second_q <= '0;
					older_q  <= '0;
					prior_q  <= '0;
					count_q  <= '0;
					box_q    <= '0;
				end else begin
					if (cnt0) begin
						first_q <= v;
					end
					if (cnt1) begin
						second_q <= v;
					end
					older_q <= prior_q;
					prior_q <= v;
					count_q <= cnt_new;
					box_q   <= box_new;
				end
			end else if (s1_ready) begin
				s1_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			s1_q <= s1_d;
		end
	end

endmodule

@@ rtl/core/pcab_prod.sv @@
// Multiply stage: the two products of each cross product and the edge products.
// All multiplies are independent and registered. Depends on pcab_pkg.
module pcab_prod import pcab_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic s1_valid,
	output logic s1_ready,
	input  s1_t  s1,
	output logic s2_valid,
	input  logic s2_ready,
	output s2_t  s2
);

	logic s2_valid_q;
	s2_t  s2_q;
	s2_t  s2_d;
	logic take;

	function automatic diff_t sub_c(coord_t a, coord_t b);
		return diff_t'(a) - diff_t'(b);
	endfunction

	function automatic diff_t add_c(coord_t a, coord_t b);
		return diff_t'(a) + diff_t'(b);
	endfunction

	function automatic prod_t mul_d(diff_t a, diff_t b);
		return prod_t'(a) * prod_t'(b);
	endfunction

	assign s1_ready = !s2_valid_q || s2_ready;
	assign take     = s1_valid && s1_ready;
	assign s2_valid = s2_valid_q;
	assign s2       = s2_q;

	// Turn at b for points a, b, c is (a - b) x (c - b) = m1 - m2.
	always_comb begin
		s2_d.last     = s1.last;
		s2_d.ta_en    = s1.ta_en;
		s2_d.ea_en    = s1.ea_en;
		s2_d.close_en = s1.close_en;
		s2_d.ta_m1    = mul_d(sub_c(s1.o.x, s1.p.x), sub_c(s1.v.y, s1.p.y));
		s2_d.ta_m2    = mul_d(sub_c(s1.o.y, s1.p.y), sub_c(s1.v.x, s1.p.x));
		s2_d.tb_m1    = mul_d(sub_c(s1.p.x, s1.v.x), sub_c(s1.f.y, s1.v.y));
		s2_d.tb_m2    = mul_d(sub_c(s1.p.y, s1.v.y), sub_c(s1.f.x, s1.v.x));
		s2_d.tc_m1    = mul_d(sub_c(s1.v.x, s1.f.x), sub_c(s1.s.y, s1.f.y));
		s2_d.tc_m2    = mul_d(sub_c(s1.v.y, s1.f.y), sub_c(s1.s.x, s1.f.x));
		s2_d.ea       = mul_d(add_c(s1.p.y, s1.v.y), sub_c(s1.v.x, s1.p.x));
		s2_d.eb       = mul_d(add_c(s1.v.y, s1.f.y), sub_c(s1.f.x, s1.v.x));
		s2_d.box      = s1.box;
		s2_d.cnt      = s1.cnt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_q <= 1'b0;
		end else if (take) begin
			s2_valid_q <= 1'b1;
		end else if (s2_ready) begin
			s2_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			s2_q <= s2_d;
		end
	end

endmodule

@@ rtl/core/pcab_acc.sv @@
// Accumulator: turn-sign flags, saturating area sum and the result register.
// Only a closing vertex waits for the result register. Depends on pcab_pkg.
module pcab_acc import pcab_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    s2_valid,
	output logic    s2_ready,
	input  s2_t     s2,
	output logic    result_valid,
	input  logic    result_ready,
	output result_t result
);

	localparam int SUM_W = ((AREA_W > PROD_W) ? AREA_W : PROD_W) + 1;
	typedef logic signed [SUM_W-1:0] sum_t;
	localparam sum_t SUM_MAX = sum_t'({1'b0, {(AREA_W-1){1'b1}}});
	localparam sum_t SUM_MIN = -SUM_MAX - sum_t'(1);

	area_t   area_q;
	logic    neg_q, pos_q;
	logic    res_valid_q;
	result_t res_q;

	logic    neg1, pos1, neg2, pos2;
	area_t   area1, area2;
	result_t res_d;
	logic    take;

	function automatic area_t sat_add(area_t acc, prod_t e);
		sum_t s;
		s = sum_t'(acc) + sum_t'(e);
		if (s > SUM_MAX) begin
			s = SUM_MAX;
		end else if (s < SUM_MIN) begin
			s = SUM_MIN;
		end
		return s[AREA_W-1:0];
	endfunction

	assign s2_ready     = !s2.last || !res_valid_q || result_ready;
	assign take         = s2_valid && s2_ready;
	assign result_valid = res_valid_q;
	assign result       = res_q;

	// The sign of a cross product m1 - m2 follows from comparing m1 with m2.
	always_comb begin
		neg1  = neg_q || (s2.ta_en && ($signed(s2.ta_m1) < $signed(s2.ta_m2)));
		pos1  = pos_q || (s2.ta_en && ($signed(s2.ta_m1) > $signed(s2.ta_m2)));
		area1 = s2.ea_en ? sat_add(area_q, s2.ea) : area_q;
		neg2  = neg1 || (s2.close_en && (($signed(s2.tb_m1) < $signed(s2.tb_m2)) ||
		                                 ($signed(s2.tc_m1) < $signed(s2.tc_m2))));
		pos2  = pos1 || (s2.close_en && (($signed(s2.tb_m1) > $signed(s2.tb_m2)) ||
		                                 ($signed(s2.tc_m1) > $signed(s2.tc_m2))));
		area2 = sat_add(area1, s2.eb);
		res_d.convex       = !s2.close_en || !(neg2 && pos2);
		res_d.double_area  = area2;
		res_d.min_x        = s2.box.min_x;
		res_d.min_y        = s2.box.min_y;
		res_d.max_x        = s2.box.max_x;
		res_d.max_y        = s2.box.max_y;
		res_d.vertex_count = s2.cnt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			area_q      <= '0;
			neg_q       <= 1'b0;
			pos_q       <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (take) begin
				if (s2.last) begin
					area_q <= '0;
					neg_q  <= 1'b0;
					pos_q  <= 1'b0;
				end else begin
					area_q <= area1;
					neg_q  <= neg1;
					pos_q  <= pos1;
				end
			end
			if (take && s2.last) begin
				res_valid_q <= 1'b1;
			end else if (result_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && s2.last) begin
			res_q <= res_d;
		end
	end

endmodule

@@ sim/tb_polygon_convexity_area_bounds.sv @@
// Testbench for polygon_convexity_area_bounds: streams polygons with random gaps and stalls.
// Predicts convexity, doubled area, bounds and count per polygon and checks each result.
// Depends on pcab_pkg and the polygon_convexity_area_bounds RTL.
module tb_polygon_convexity_area_bounds import pcab_pkg::*; ;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CYCLE_LIMIT  = 600000;
	localparam int unsigned DRAIN_CYCLES = 10;
	localparam int unsigned LONG_HOLD    = 300;
	localparam int unsigned RANDOM_ITEMS = 700;
	localparam longint      AREA_HI      = (longint'(1) <<< (AREA_W - 1)) - 1;
	localparam longint      AREA_LO      = -(longint'(1) <<< (AREA_W - 1));
	localparam coord_t      COORD_HI     = coord_t'(16'h7fff);
	localparam coord_t      COORD_LO     = coord_t'(16'h8000);

	typedef enum int unsigned {
		SHAPE_SCATTER,
		SHAPE_CLUSTER,
		SHAPE_RECT,
		SHAPE_EXTREME,
		SHAPE_LINE,
		SHAPE_LAPS_UP,
		SHAPE_LAPS_DOWN
	} shape_kind_t;

	typedef struct {
		vertex_t     v;
		int unsigned gap;
		bit          drain;
	} vertex_slot_t;

	logic    clk;
	logic    arst_n;
	logic    vertex_valid = 1'b0;
	logic    vertex_ready;
	vertex_t vertex       = '0;
	logic    result_valid;
	logic    result_ready = 1'b0;
	result_t result;

	vertex_slot_t vertex_feed[$];
	result_t      expected_shapes[$];
	int unsigned  fault_count  = 0;
	int unsigned  feed_total   = 0;
	int unsigned  results_seen = 0;
	int unsigned  cycle_count  = 0;
	bit           tx_calm      = 1'b0;
	bit           rx_calm      = 1'b0;
	int unsigned  rx_stall     = 0;
	int unsigned  rx_hold      = 0;

	// Running state of the polygon being predicted.
	coord_t shape_first_x, shape_first_y, shape_second_x, shape_second_y;
	coord_t shape_older_x, shape_older_y, shape_prior_x, shape_prior_y;
	coord_t shape_lo_x, shape_lo_y, shape_hi_x, shape_hi_y;
	count_t shape_count;
	bit     turned_cw, turned_ccw;
	longint area_acc;

	polygon_convexity_area_bounds DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.vertex_valid (vertex_valid),
		.vertex_ready (vertex_ready),
		.vertex       (vertex),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic void clear_shape();
		shape_first_x  = '0;
		shape_first_y  = '0;
		shape_second_x = '0;
		shape_second_y = '0;
		shape_older_x  = '0;
		shape_older_y  = '0;
		shape_prior_x  = '0;
		shape_prior_y  = '0;
		shape_lo_x     = '0;
		shape_lo_y     = '0;
		shape_hi_x     = '0;
		shape_hi_y     = '0;
		shape_count    = '0;
		turned_cw      = 1'b0;
		turned_ccw     = 1'b0;
		area_acc       = 0;
	endfunction

	// Sign of the turn at b going from a to c; a straight line sets neither flag.
	function automatic void note_turn(input longint ax, ay, bx, by, cx, cy);
		longint cr;
		cr = (ax - bx) * (cy - by) - (ay - by) * (cx - bx);
		if (cr < 0)
			turned_cw = 1'b1;
		else if (cr > 0)
			turned_ccw = 1'b1;
	endfunction

	function automatic void add_edge(input longint ax, ay, bx, by);
		longint s;
		s = area_acc + (ay + by) * (bx - ax);
		if (s > AREA_HI)
			s = AREA_HI;
		else if (s < AREA_LO)
			s = AREA_LO;
		area_acc = s;
	endfunction

	function automatic void track_vertex(input vertex_t v);
		result_t r;
		if (shape_count == 0) begin
			shape_first_x = v.x;
			shape_first_y = v.y;
			shape_lo_x    = v.x;
			shape_hi_x    = v.x;
			shape_lo_y    = v.y;
			shape_hi_y    = v.y;
		end else begin
			if (shape_count == 1) begin
				shape_second_x = v.x;
				shape_second_y = v.y;
			end else begin
				note_turn(shape_older_x, shape_older_y, shape_prior_x, shape_prior_y, v.x, v.y);
			end
			add_edge(shape_prior_x, shape_prior_y, v.x, v.y);
			if (v.x < shape_lo_x) shape_lo_x = v.x;
			if (v.x > shape_hi_x) shape_hi_x = v.x;
			if (v.y < shape_lo_y) shape_lo_y = v.y;
			if (v.y > shape_hi_y) shape_hi_y = v.y;
		end
		shape_older_x = shape_prior_x;
		shape_older_y = shape_prior_y;
		shape_prior_x = v.x;
		shape_prior_y = v.y;
		if (shape_count < MAX_COUNT)
			shape_count = shape_count + 1'b1;
		if (v.last) begin
			// Close the polygon: the two wrap-around turns and the edge back to the start.
			if (shape_count >= MIN_TURNS) begin
				note_turn(shape_older_x, shape_older_y, shape_prior_x, shape_prior_y,
					shape_first_x, shape_first_y);
				note_turn(shape_prior_x, shape_prior_y, shape_first_x, shape_first_y,
					shape_second_x, shape_second_y);
			end
			add_edge(shape_prior_x, shape_prior_y, shape_first_x, shape_first_y);
			r.convex       = (shape_count < MIN_TURNS) || !(turned_cw && turned_ccw);
			r.double_area  = area_t'(area_acc);
			r.min_x        = shape_lo_x;
			r.min_y        = shape_lo_y;
			r.max_x        = shape_hi_x;
			r.max_y        = shape_hi_y;
			r.vertex_count = shape_count;
			expected_shapes.push_back(r);
			clear_shape();
		end
	endfunction

	function automatic void check_shape(input result_t got);
		result_t want;
		if (expected_shapes.size() == 0) begin
			$error("result with no polygon pending: area %0d, count %0d",
				got.double_area, got.vertex_count);
			fault_count++;
		end else begin
			want = expected_shapes.pop_front();
			if (got.convex !== want.convex) begin
				$error("convex: expected %0d, got %0d", want.convex, got.convex);
				fault_count++;
			end
			if (got.double_area !== want.double_area) begin
				$error("double_area: expected %0d, got %0d", want.double_area, got.double_area);
				fault_count++;
			end
			if (got.min_x !== want.min_x) begin
				$error("min_x: expected %0d, got %0d", want.min_x, got.min_x);
				fault_count++;
			end
			if (got.min_y !== want.min_y) begin
				$error("min_y: expected %0d, got %0d", want.min_y, got.min_y);
				fault_count++;
			end
			if (got.max_x !== want.max_x) begin
				$error("max_x: expected %0d, got %0d", want.max_x, got.max_x);
				fault_count++;
			end
			if (got.max_y !== want.max_y) begin
				$error("max_y: expected %0d, got %0d", want.max_y, got.max_y);
				fault_count++;
			end
			if (got.vertex_count !== want.vertex_count) begin
				$error("vertex_count: expected %0d, got %0d", want.vertex_count,
					got.vertex_count);
				fault_count++;
			end
		end
	endfunction

	function automatic void offer(input coord_t x, input coord_t y, input bit last);
		vertex_slot_t s;
		s.v.x   = x;
		s.v.y   = y;
		s.v.last = last;
		s.gap   = tx_calm ? 0 : $urandom_range(0, 5);
		s.drain = 1'b0;
		vertex_feed.push_back(s);
		feed_total++;
	endfunction

	// The sender stops here until every polygon sent so far has its result.
	function automatic void wait_for_results();
		vertex_slot_t s;
		s.v     = '0;
		s.gap   = 0;
		s.drain = 1'b1;
		vertex_feed.push_back(s);
	endfunction

	function automatic coord_t any_coord();
		return coord_t'($urandom_range(0, 65535));
	endfunction

	function automatic coord_t edge_coord();
		case ($urandom_range(0, 3))
			0: return COORD_LO;
			1: return COORD_HI;
			2: return '0;
			default: return any_coord();
		endcase
	endfunction

	function automatic void add_polygon(input int unsigned n, input shape_kind_t kind);
		coord_t      bx, by, px, py;
		int unsigned start, c, k;
		bit          ccw;
		bx    = any_coord();
		by    = any_coord();
		px    = any_coord();
		py    = any_coord();
		ccw   = $urandom_range(0, 1);
		start = $urandom_range(0, 3);
		case (kind)
			SHAPE_SCATTER:
				for (k = 0; k < n; k++)
					offer(any_coord(), any_coord(), k == n - 1);
			SHAPE_CLUSTER:
				for (k = 0; k < n; k++)
					offer(coord_t'(bx + $urandom_range(0, 16) - 8),
						coord_t'(by + $urandom_range(0, 16) - 8), k == n - 1);
			SHAPE_RECT: begin
				offer(bx, by, 1'b0);
				if (ccw) offer(px, by, 1'b0);
				else offer(bx, py, 1'b0);
				offer(px, py, 1'b0);
				if (ccw) offer(bx, py, 1'b1);
				else offer(px, by, 1'b1);
			end
			SHAPE_EXTREME:
				for (k = 0; k < n; k++)
					offer(edge_coord(), edge_coord(), k == n - 1);
			SHAPE_LINE:
				for (k = 0; k < n; k++)
					offer(bx, any_coord(), k == n - 1);
			default:
				// Laps around the full-range square pile up area in one direction.
				for (k = 0; k < n; k++) begin
					c = (kind == SHAPE_LAPS_UP) ? (start + k) % 4 : (start + 4 - k % 4) % 4;
					offer((c == 1 || c == 2) ? COORD_HI : COORD_LO,
						(c <= 1) ? COORD_HI : COORD_LO, k == n - 1);
				end
		endcase
	endfunction

	// Sender: each queued vertex waits out its gap, then stays offered until taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_valid <= 1'b0;
			vertex       <= '0;
		end else begin
			if (vertex_valid && vertex_ready)
				track_vertex(vertex);
			if (!vertex_valid || vertex_ready) begin
				if (vertex_feed.size() == 0) begin
					vertex_valid <= 1'b0;
				end else if (vertex_feed[0].drain) begin
					vertex_valid <= 1'b0;
					if (expected_shapes.size() == 0)
						void'(vertex_feed.pop_front());
				end else if (vertex_feed[0].gap != 0) begin
					vertex_valid <= 1'b0;
					vertex_feed[0].gap = vertex_feed[0].gap - 1;
				end else begin
					vertex_valid <= 1'b1;
					vertex       <= vertex_feed[0].v;
					void'(vertex_feed.pop_front());
				end
			end
		end
	end

	// Receiver: random stalls after each transfer, two long hold-offs partway through.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else begin
			if (result_valid && result_ready) begin
				check_shape(result);
				results_seen++;
				if ($urandom_range(0, 15) == 0)
					rx_calm = !rx_calm;
				rx_stall = rx_calm ? 0 : $urandom_range(0, 5);
				if (results_seen == 20 || results_seen == 90)
					rx_hold = LONG_HOLD;
			end
			if (rx_hold != 0) begin
				rx_hold--;
				result_ready <= 1'b0;
			end else if (rx_stall != 0) begin
				rx_stall--;
				result_ready <= 1'b0;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb_polygon_convexity_area_bounds failed");
			$finish;
		end
	end

	initial begin
		int unsigned directed_total, polygons, pick, n;
		arst_n = 1'b0;
		clear_shape();

		// Directed polygons: lone vertex, two vertices, both triangle windings,
		// a straight line, a dented quad and the full-range square.
		offer(COORD_LO, COORD_HI, 1'b1);
		offer(COORD_HI, COORD_LO, 1'b0);
		offer(COORD_LO, COORD_HI, 1'b1);
		offer(16'sd0, 16'sd0, 1'b0);
		offer(16'sd10, 16'sd0, 1'b0);
		offer(16'sd0, 16'sd10, 1'b1);
		offer(16'sd0, 16'sd10, 1'b0);
		offer(16'sd10, 16'sd0, 1'b0);
		offer(16'sd0, 16'sd0, 1'b1);
		offer(16'sd0, 16'sd0, 1'b0);
		offer(16'sd5, 16'sd5, 1'b0);
		offer(16'sd10, 16'sd10, 1'b1);
		offer(16'sd0, 16'sd0, 1'b0);
		offer(16'sd10, 16'sd0, 1'b0);
		offer(16'sd2, 16'sd2, 1'b0);
		offer(16'sd0, 16'sd10, 1'b1);
		offer(COORD_LO, COORD_LO, 1'b0);
		offer(COORD_HI, COORD_LO, 1'b0);
		offer(COORD_HI, COORD_HI, 1'b0);
		offer(COORD_LO, COORD_HI, 1'b1);
		wait_for_results();
		directed_total = feed_total;

		polygons = 0;
		while (feed_total - directed_total < RANDOM_ITEMS) begin
			if ($urandom_range(0, 5) == 0)
				tx_calm = !tx_calm;
			pick = $urandom_range(0, 19);
			if (pick < 16)
				n = $urandom_range(1, 10);
			else if (pick < 19)
				n = $urandom_range(11, 40);
			else
				n = $urandom_range(1, 3);
			add_polygon(n, shape_kind_t'($urandom_range(SHAPE_SCATTER, SHAPE_LINE)));
			polygons++;
			if (polygons == 60)
				wait_for_results();
		end

		// Several laps around the full-range square in both directions for large areas.
		tx_calm = 1'b0;
		add_polygon(40, SHAPE_LAPS_UP);
		add_polygon(40, SHAPE_LAPS_DOWN);
		add_polygon(5, SHAPE_SCATTER);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		while (vertex_feed.size() != 0 || vertex_valid || expected_shapes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fault_count == 0)
			$display("tb_polygon_convexity_area_bounds passed");
		else
			$display("tb_polygon_convexity_area_bounds failed");
		$finish;
	end

endmodule
